// ===== design/utf8d_pkg.sv =====
// Package for the UTF-8 decoder: widths, constants, shared types and the
// window decode and shift functions.
// No dependencies.
package utf8d_pkg;

  localparam int BYTE_W    = 8;
  localparam int CP_W      = 21;
  localparam int WIN_DEPTH = 4;
  localparam int IDX_W     = $clog2(WIN_DEPTH);
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

  localparam logic [CP_W-1:0] REPL_CP = CP_W'(32'h0000_FFFD);

  typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_t;

  // Outcome of one decode pass over the head of the window.
  typedef struct packed {
    logic             emit;
    logic             rep;
    logic [CNT_W-1:0] drop;   // bytes removed from the front
    logic [CP_W-1:0]  cp;
  } dec_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            run_end;
    logic            text_end;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t res;
  } res_load_t;

  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] cnt;
  } win_stat_t;

  // Decode the sequence at the front of the window.
  function automatic dec_t decode_win(win_t w, logic [CNT_W-1:0] cnt, logic last);
    dec_t             d;
    logic [CNT_W-1:0] need;
    logic             bad;
    logic             cont_ok;
    logic [CP_W-1:0]  cp;
    d       = '0;
    need    = CNT_W'(1);
    bad     = 1'b0;
    cont_ok = 1'b1;
    if (w[0][7] == 1'b0) begin
      need = CNT_W'(1);
    end else if (w[0][7:5] == 3'b110) begin
      need = CNT_W'(2);
    end else if (w[0][7:4] == 4'b1110) begin
      need = CNT_W'(3);
    end else if (w[0][7:3] == 5'b11110) begin
      need = CNT_W'(4);
    end else begin
      bad = 1'b1;
    end
    for (int i = 1; i < WIN_DEPTH; i++) begin
      if ((CNT_W'(i) < need) && (w[i][7:6] != 2'b10)) begin
        cont_ok = 1'b0;
      end
    end
    case (need)
      CNT_W'(2): cp = {10'd0, w[0][4:0], w[1][5:0]};
      CNT_W'(3): cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
      CNT_W'(4): cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
      default:   cp = {13'd0, w[0]};
    endcase
    if (cnt == '0) begin
      d.emit = 1'b0;
    end else if (bad) begin
      d.emit = 1'b1;
      d.rep  = 1'b1;
      d.cp   = REPL_CP;
      d.drop = CNT_W'(1);
    end else if (cnt < need) begin
      if (last) begin
        // text ends mid-sequence: one replacement, window flushed
        d.emit = 1'b1;
        d.rep  = 1'b1;
        d.cp   = REPL_CP;
        d.drop = cnt;
      end
    end else if (cont_ok) begin
      d.emit = 1'b1;
      d.cp   = cp;
      d.drop = need;
    end else begin
      d.emit = 1'b1;
      d.rep  = 1'b1;
      d.cp   = REPL_CP;
      d.drop = CNT_W'(1);
    end
    return d;
  endfunction

  // Remove k bytes from the front of the window.
  function automatic win_t shift_win(win_t w, logic [CNT_W-1:0] k);
    win_t             s;
    logic [CNT_W-1:0] j;
    s = w;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      j = CNT_W'(i) + k;
      if (j < CNT_W'(WIN_DEPTH)) begin
        s[i] = w[j[IDX_W-1:0]];
      end
    end
    return s;
  endfunction

endpackage

// ===== design/utf8d_if.sv =====
// Channel interfaces of the UTF-8 decoder: byte input and code point output.
// Depends on utf8d_pkg.
interface utf8d_in_if;
  logic                          valid;
  logic                          ready;
  logic [utf8d_pkg::BYTE_W-1:0]  text_byte;
  logic                          final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface utf8d_out_if;
  logic                         valid;
  logic                         ready;
  logic [utf8d_pkg::CP_W-1:0]   code_point;
  logic                         replaced;
  logic                         run_end;
  logic                         text_end;

  modport source (output valid, output code_point, output replaced, output run_end,
                  output text_end, input ready);
  modport sink   (input valid, input code_point, input replaced, input run_end,
                  input text_end, output ready);
endinterface

// ===== design/utf8d_window.sv =====
// Byte window and decode sequencer: one decode pass per cycle while res_free is high,
// next byte taken in the cycle that ends the current run. Depends on utf8d_pkg, utf8d_if.
module utf8d_window (
  input  logic                  clk,
  input  logic                  rst_n,
  utf8d_in_if.sink              in_ch,
  input  logic                  res_free,
  output utf8d_pkg::res_load_t  res_ld,
  output utf8d_pkg::win_stat_t  stat
);
  import utf8d_pkg::*;

  win_t             win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             active_r, active_nxt;

  dec_t             dec_cur, dec_rem;
  win_t             rem_win, base_win;
  logic [CNT_W-1:0] rem_cnt, base_cnt;
  logic             emit, fire, step_done, accept;

  always_comb begin
    dec_cur   = decode_win(win_r, cnt_r, last_r);
    emit      = active_r && dec_cur.emit;
    rem_win   = shift_win(win_r, dec_cur.drop);
    rem_cnt   = cnt_r - dec_cur.drop;
    // lookahead: does the window left behind give another result?
    dec_rem   = decode_win(rem_win, rem_cnt, last_r);
    fire      = emit && res_free;
    step_done = !emit || (fire && !dec_rem.emit);
    accept    = in_ch.valid && step_done;

    base_win = fire ? rem_win : win_r;
    base_cnt = fire ? rem_cnt : cnt_r;

    win_nxt    = base_win;
    cnt_nxt    = base_cnt;
    last_nxt   = last_r;
    active_nxt = active_r;
    if (accept) begin
      win_nxt[base_cnt[IDX_W-1:0]] = in_ch.text_byte;
      cnt_nxt    = base_cnt + CNT_W'(1);
      last_nxt   = in_ch.final_byte;
      active_nxt = 1'b1;
    end else if (step_done) begin
      active_nxt = 1'b0;
    end
  end

  assign in_ch.ready = step_done;

  always_comb begin
    res_ld.load           = fire;
    res_ld.res.code_point = dec_cur.cp;
    res_ld.res.replaced   = dec_cur.rep;
    res_ld.res.run_end    = !dec_rem.emit;
    res_ld.res.text_end   = !dec_rem.emit && last_r;
    stat.active           = active_r;
    stat.cnt              = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      active_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== design/utf8d_result_reg.sv =====
// Output register of the UTF-8 decoder; holds one result until taken.
// Depends on utf8d_pkg, utf8d_if.
module utf8d_result_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf8d_pkg::res_load_t res_ld,
  output logic                 res_free,
  utf8d_out_if.source          out_ch
);
  import utf8d_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  always_comb begin
    res_free  = !valid_r || out_ch.ready;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res_ld.load) begin
      valid_nxt = 1'b1;
      data_nxt  = res_ld.res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.code_point = data_r.code_point;
  assign out_ch.replaced   = data_r.replaced;
  assign out_ch.run_end    = data_r.run_end;
  assign out_ch.text_end   = data_r.text_end;

endmodule

// ===== design/utf8_decoder_with_replacement_unit.sv =====
// UTF-8 decoder with U+FFFD replacement. Top level; depends on utf8d_pkg,
// utf8d_if, utf8d_window and utf8d_result_reg.
//
// Takes one text byte per transaction and returns code points. Bytes collect
// in a four-byte window. Once the window holds the whole sequence named by its
// lead byte, one decode pass per cycle, while the output register is free,
// turns the front of the window into one result, which lands in the output
// register. A byte is taken in any cycle in which no result of the previous
// byte is still to be produced. A byte that releases several results (at most
// four, after bad continuation bytes are re-read as leads) holds input ready
// low until the cycle of its last result. Well-formed text and isolated bad
// bytes run at one byte per cycle while the output register is free. Apart
// from back pressure, only a byte that releases several results stretches
// its slot, for example the last byte after a lead whose continuation bytes
// were bad. A byte is registered in the window, and its result then in the
// output register. run_end marks the last result of one input byte,
// text_end the last result of a text. No overlong or surrogate checks are made.
module utf8_decoder_with_replacement_unit (
  input  logic         clk,
  input  logic         rst_n,
  utf8d_in_if.sink     in_ch,
  utf8d_out_if.source  out_ch
);
  import utf8d_pkg::*;

  res_load_t res_ld;
  win_stat_t stat;
  logic      res_free;

  // window, decode passes and input handshake
  utf8d_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .res_free (res_free),
    .res_ld   (res_ld),
    .stat     (stat)
  );

  // output register, decouples the result side from the window
  utf8d_result_reg u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_ld   (res_ld),
    .res_free (res_free),
    .out_ch   (out_ch)
  );

  // a result is never written over one not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld.load |-> res_free)
    else $error("result register overwritten");

  // no new byte while the current byte still owes results
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (res_ld.load && !res_ld.res.run_end) |-> !(in_ch.valid && in_ch.ready))
    else $error("byte taken in the middle of a run");

  // end of text leaves the window empty, apart from a byte taken alongside
  a_text_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (res_ld.load && res_ld.res.text_end) |=> (stat.cnt <= CNT_W'(1)))
    else $error("window not flushed at end of text");

  // an idle window holds only an incomplete sequence
  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.active |-> (stat.cnt < CNT_W'(WIN_DEPTH)))
    else $error("idle window is full");

endmodule
